[rtl/ssd_pkg.sv]
// Shared constants and types for the saturation step damping unit.
package ssd_pkg;

    localparam int VALUE_FRAC_BITS   = 24;
    localparam int DAMPING_FRAC_BITS = 16;

    localparam int FIELD_BITS    = 32;
    localparam int FRAC_REG_BITS = 16;
    localparam logic [FRAC_REG_BITS-1:0] FRAC_RESET = 16'd58982;

    // width that holds every sum formed from the fields
    localparam int WIDE_BITS = 37;
    localparam int DIV_BITS  = 36;

    localparam int PDATA_BITS = 32;
    localparam int PADDR_BITS = 3;

    localparam logic REG_FRAC = 1'b0;
    localparam logic REG_MAX  = 1'b1;

    typedef enum logic [1:0] {
        RULE_FIRST  = 2'd0,
        RULE_SECOND = 2'd1,
        RULE_TOTAL  = 2'd2
    } t_rule;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PREP  = 8'b0000_0010,
        S_OLD   = 8'b0000_0100,
        S_SETUP = 8'b0000_1000,
        S_CHK   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_MUL   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

endpackage

[rtl/saturation_step_damping_unit.sv]
// Fraction-to-boundary step damping over a stream of saturation coefficients.
// Per item: prep, then for each bound rule the old, setup and check states; a firing rule
// adds the divider and multiply states, skipping the divider when its ratio caps at one.
// At most two rules fire. A new item is taken only in idle, after the last one is done.
// The result sits in an output register; only a last coefficient waits for it to drain.
// Synchronous active-low reset: damping back to one, control and config registers to defaults.
module saturation_step_damping_unit #(
    parameter int VALUE_FRAC_BITS   = ssd_pkg::VALUE_FRAC_BITS,
    parameter int DAMPING_FRAC_BITS = ssd_pkg::DAMPING_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [ssd_pkg::PADDR_BITS-1:0]         paddr,
    input  logic [ssd_pkg::PDATA_BITS-1:0]         pwdata,
    output logic [ssd_pkg::PDATA_BITS-1:0]         prdata,
    output logic                                   pready,

    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [ssd_pkg::FIELD_BITS-1:0]  i_first_backbone_new,
    input  logic signed [ssd_pkg::FIELD_BITS-1:0]  i_second_backbone_new,
    input  logic signed [ssd_pkg::FIELD_BITS-1:0]  i_first_enrichment_new,
    input  logic signed [ssd_pkg::FIELD_BITS-1:0]  i_second_enrichment_new,
    input  logic signed [ssd_pkg::FIELD_BITS-1:0]  i_first_backbone_update,
    input  logic signed [ssd_pkg::FIELD_BITS-1:0]  i_second_backbone_update,
    input  logic signed [ssd_pkg::FIELD_BITS-1:0]  i_first_enrichment_update,
    input  logic signed [ssd_pkg::FIELD_BITS-1:0]  i_second_enrichment_update,
    input  logic                                   i_last_coefficient,

    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [DAMPING_FRAC_BITS:0]             o_damping_factor
);

    localparam int WB   = ssd_pkg::WIDE_BITS;
    localparam int DB   = ssd_pkg::DIV_BITS;
    localparam int FB   = ssd_pkg::FRAC_REG_BITS;
    localparam int MAXW = VALUE_FRAC_BITS + 1;
    localparam int DW   = DAMPING_FRAC_BITS + 1;
    localparam int PW   = DW + FB;
    localparam int CW   = $clog2(DAMPING_FRAC_BITS);
    localparam logic [DW-1:0]   DAMP_ONE  = DW'(1) << DAMPING_FRAC_BITS;
    localparam logic [MAXW-1:0] MAX_RESET = MAXW'(1) << VALUE_FRAC_BITS;
    localparam logic [CW-1:0]   CNT_LAST  = CW'(DAMPING_FRAC_BITS - 1);

    ssd_pkg::t_state r_state, n_state;
    ssd_pkg::t_rule  r_rule;

    logic [FB-1:0]   r_frac;
    logic [MAXW-1:0] r_max;

    logic signed [WB-1:0] r_s1, r_s2, r_d1, r_d2, r_ssum, r_dsum;
    logic signed [WB-1:0] r_cand, r_step, r_old;
    logic                 r_last;
    logic                 r_fire;
    logic [DB-1:0]        r_num, r_den, r_rem;
    logic [DW-1:0]        r_q, r_prod, r_run;
    logic [CW-1:0]        r_cnt;
    logic                 r_out_valid;
    logic [DW-1:0]        r_out;

    logic                 w_in_xfer, w_cfg_wr, w_last_rule, w_out_free;
    logic signed [WB-1:0] w_bound, w_cand, w_step, w_unum, w_uden;
    logic                 w_fire_lo, w_fire_hi;
    logic [DB:0]          w_rem2;
    logic                 w_ge;
    logic [PW-1:0]        w_prod;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            ssd_pkg::REG_FRAC: prdata = ssd_pkg::PDATA_BITS'(r_frac);
            ssd_pkg::REG_MAX:  prdata = ssd_pkg::PDATA_BITS'(r_max);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frac <= ssd_pkg::FRAC_RESET;
            r_max  <= MAX_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                ssd_pkg::REG_FRAC: r_frac <= pwdata[FB-1:0];
                ssd_pkg::REG_MAX:  r_max  <= pwdata[MAXW-1:0];
                default: ;
            endcase
        end
    end

    // handshakes
    assign o_in_ready       = (r_state == ssd_pkg::S_IDLE);
    assign w_in_xfer        = i_in_valid && o_in_ready;
    assign o_out_valid      = r_out_valid;
    assign o_damping_factor = r_out;
    assign w_out_free       = !r_out_valid || i_out_ready;
    assign w_last_rule      = (r_rule == ssd_pkg::RULE_TOTAL);

    // rule operands
    assign w_bound = $signed(WB'(r_max));

    always_comb begin
        case (r_rule)
            ssd_pkg::RULE_FIRST: begin
                w_cand = r_s1;
                w_step = r_d1;
            end
            ssd_pkg::RULE_SECOND: begin
                w_cand = r_s2;
                w_step = r_d2;
            end
            default: begin
                w_cand = r_ssum;
                w_step = r_dsum;
            end
        endcase
    end

    assign w_unum    = w_bound - r_old;
    assign w_uden    = -r_step;
    assign w_fire_lo = r_cand[WB-1] && !r_old[WB-1] && (r_step != '0);
    assign w_fire_hi = (r_cand > w_bound) && (r_old <= w_bound) && (r_step != '0);

    // shared divider step and scaling multiply
    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});
    assign w_prod = PW'(r_q) * PW'(r_frac);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssd_pkg::S_IDLE:  if (w_in_xfer) n_state = ssd_pkg::S_PREP;
            ssd_pkg::S_PREP:  n_state = ssd_pkg::S_OLD;
            ssd_pkg::S_OLD:   n_state = ssd_pkg::S_SETUP;
            ssd_pkg::S_SETUP: n_state = ssd_pkg::S_CHK;
            ssd_pkg::S_CHK: begin
                if (!r_fire) begin
                    n_state = w_last_rule ? ssd_pkg::S_DONE : ssd_pkg::S_OLD;
                end else if (r_num >= r_den) begin
                    n_state = ssd_pkg::S_MUL;
                end else begin
                    n_state = ssd_pkg::S_DIV;
                end
            end
            ssd_pkg::S_DIV:   if (r_cnt == CNT_LAST) n_state = ssd_pkg::S_MUL;
            ssd_pkg::S_MUL:   n_state = w_last_rule ? ssd_pkg::S_DONE : ssd_pkg::S_OLD;
            ssd_pkg::S_DONE: begin
                if (!r_last || w_out_free) n_state = ssd_pkg::S_IDLE;
            end
            default:          n_state = ssd_pkg::S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssd_pkg::S_IDLE;
            r_rule      <= ssd_pkg::RULE_FIRST;
            r_run       <= DAMP_ONE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;

            if (r_state == ssd_pkg::S_DONE && r_last && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ssd_pkg::S_PREP: r_rule <= ssd_pkg::RULE_FIRST;
                ssd_pkg::S_CHK: begin
                    r_cnt <= '0;
                    if (!r_fire && !w_last_rule) r_rule <= ssd_pkg::t_rule'(r_rule + 2'd1);
                end
                ssd_pkg::S_DIV: r_cnt <= r_cnt + CW'(1);
                ssd_pkg::S_MUL: begin
                    // keep the smaller of the scaled ratio and the running minimum
                    if (w_prod[PW-1:FB] < r_run) r_run <= w_prod[PW-1:FB];
                    if (!w_last_rule) r_rule <= ssd_pkg::t_rule'(r_rule + 2'd1);
                end
                ssd_pkg::S_DONE: begin
                    if (r_last && w_out_free) begin
                        r_run <= DAMP_ONE;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1   <= WB'(i_first_backbone_new) + WB'(i_first_enrichment_new);
            r_s2   <= WB'(i_second_backbone_new) + WB'(i_second_enrichment_new);
            r_d1   <= WB'(i_first_backbone_update) + WB'(i_first_enrichment_update);
            r_d2   <= WB'(i_second_backbone_update) + WB'(i_second_enrichment_update);
            r_last <= i_last_coefficient;
        end

        if (r_state == ssd_pkg::S_PREP) begin
            r_ssum <= r_s1 + r_s2;
            r_dsum <= r_d1 + r_d2;
        end

        if (r_state == ssd_pkg::S_OLD) begin
            r_cand <= w_cand;
            r_step <= w_step;
            r_old  <= w_cand + w_step;
        end

        if (r_state == ssd_pkg::S_SETUP) begin
            if (w_last_rule) begin
                r_fire <= w_fire_hi;
                r_num  <= w_unum[DB-1:0];
                r_den  <= w_uden[DB-1:0];
            end else begin
                r_fire <= w_fire_lo;
                r_num  <= r_old[DB-1:0];
                r_den  <= r_step[DB-1:0];
            end
        end

        if (r_state == ssd_pkg::S_CHK) begin
            r_rem <= r_num;
            r_q   <= (r_num >= r_den) ? DAMP_ONE : '0;
        end

        if (r_state == ssd_pkg::S_DIV) begin
            r_rem <= w_ge ? w_rem2[DB-1:0] - r_den : w_rem2[DB-1:0];
            r_q   <= {r_q[DW-2:0], w_ge};
        end

        if (r_state == ssd_pkg::S_MUL) begin
            r_prod <= w_prod[PW-1:FB];
        end

        if (r_state == ssd_pkg::S_DONE && r_last && w_out_free) begin
            r_out <= r_run;
        end
    end

`ifndef SYNTH
    a_run_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run <= DAMP_ONE)
        else $error("running damping above one");

    a_out_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_damping_factor <= DAMP_ONE))
        else $error("damping result above one");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ssd_pkg::S_PREP))
        else $error("accepted transfer did not start the sequence");

    a_div_quot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ssd_pkg::S_DIV) |-> (r_q < DAMP_ONE) && (r_rem < r_den))
        else $error("divider partial quotient or remainder out of range");

    a_prod_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state == ssd_pkg::S_MUL) && i_rst_n && $past(i_rst_n)
            |-> (r_run <= r_prod) || (r_state == ssd_pkg::S_IDLE))
        else $error("minimum not updated by scaled ratio");
`endif

endmodule
